FILE: design/rpfc_pkg.sv
// Package for the RGB pixel format converter.
// Holds cfg_t, byte-count and register codes and field helpers; no dependencies.
package rpfc_pkg;

  localparam int ChannelBits = 16;
  localparam int DivStages   = 16;
  localparam logic [15:0] ChanMask = 16'((32'd1 << ChannelBits) - 32'd1);

  localparam logic [2:0] Bytes1 = 3'd1;
  localparam logic [2:0] Bytes2 = 3'd2;
  localparam logic [2:0] Bytes4 = 3'd4;

  localparam logic [2:0] RegSrcMaxes  = 3'd0;
  localparam logic [2:0] RegDstMaxes  = 3'd1;
  localparam logic [2:0] RegSrcShifts = 3'd2;
  localparam logic [2:0] RegDstShifts = 3'd3;
  localparam logic [2:0] RegSrcBytes  = 3'd4;
  localparam logic [2:0] RegDstBytes  = 3'd5;

  typedef struct packed {
    logic [47:0] src_maxes;
    logic [47:0] dst_maxes;
    logic [14:0] src_shifts;
    logic [14:0] dst_shifts;
    logic [2:0]  src_bytes;
    logic [2:0]  dst_bytes;
  } cfg_t;

  function automatic logic [15:0] field_max(logic [47:0] packed_maxes, int ch);
    return packed_maxes[16*ch +: 16] & ChanMask;
  endfunction

  function automatic logic [4:0] field_shift(logic [14:0] packed_shifts, int ch);
    return packed_shifts[5*ch +: 5];
  endfunction

  function automatic logic bytes_ok(logic [2:0] b);
    return (b == Bytes1) || (b == Bytes2) || (b == Bytes4);
  endfunction

endpackage

FILE: design/rgb_pixel_format_convert_top.sv
// Top level of the RGB pixel format converter: config registers and pipeline.
// Depends on rpfc_pkg, rpfc_extract, rpfc_div, rpfc_pack.
//
//   port group              dir  beat marked by
//   start/source_pixel_i    in   start && !busy
//   cfg_*                   in   cfg_we_i
//   target_pixel_o          out  result_valid_o (one cycle)
//
// One pixel enters per cycle; each result passes from its start beat through
// three front stages (mask, extract, multiply), 16 divider stages at one quotient
// bit each, and one output register. busy is always low: every stage advances
// each cycle. Reset clears valid bits and loads the default 8:8:8 layout.
module rgb_pixel_format_convert_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] source_pixel_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [47:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [31:0] target_pixel_o
);

  localparam int Latency = rpfc_pkg::DivStages + 4;

  rpfc_pkg::cfg_t   cfg_q;
  logic             ext_valid, div_valid;
  logic [2:0]       div_valid_ch;
  logic [2:0][31:0] num;
  logic [2:0][15:0] quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_maxes  <= 48'h00FF_00FF_00FF;
      cfg_q.dst_maxes  <= 48'h00FF_00FF_00FF;
      cfg_q.src_shifts <= 15'd272;
      cfg_q.dst_shifts <= 15'd272;
      cfg_q.src_bytes  <= rpfc_pkg::Bytes4;
      cfg_q.dst_bytes  <= rpfc_pkg::Bytes4;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rpfc_pkg::RegSrcMaxes:  cfg_q.src_maxes  <= cfg_data_i;
        rpfc_pkg::RegDstMaxes:  cfg_q.dst_maxes  <= cfg_data_i;
        rpfc_pkg::RegSrcShifts: cfg_q.src_shifts <= cfg_data_i[14:0];
        rpfc_pkg::RegDstShifts: cfg_q.dst_shifts <= cfg_data_i[14:0];
        rpfc_pkg::RegSrcBytes:  cfg_q.src_bytes  <= cfg_data_i[2:0];
        rpfc_pkg::RegDstBytes:  cfg_q.dst_bytes  <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  rpfc_extract u_extract (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (start && !busy),
    .pixel_i (source_pixel_i),
    .valid_o (ext_valid),
    .num_o   (num)
  );

  for (genvar ch = 0; ch < 3; ch++) begin : g_div
    rpfc_div u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (ext_valid),
      .num_i   (num[ch]),
      .den_i   (rpfc_pkg::field_max(cfg_q.src_maxes, ch)),
      .valid_o (div_valid_ch[ch]),
      .quo_o   (quo[ch])
    );
  end

  assign div_valid = div_valid_ch[0];

  rpfc_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (div_valid),
    .quo_i   (quo),
    .valid_o (result_valid_o),
    .pixel_o (target_pixel_o)
  );

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##Latency result_valid_o)
    else $error("result beat missing after start");

  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_valid_ch[0] == div_valid_ch[1] && div_valid_ch[1] == div_valid_ch[2])
    else $error("divider lanes out of step");

  a_trunc1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && $past(cfg_q.dst_bytes) == rpfc_pkg::Bytes1
      |-> target_pixel_o[31:8] == 24'd0)
    else $error("1-byte target has upper bits set");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !rpfc_pkg::bytes_ok($past(cfg_q.dst_bytes)) |-> target_pixel_o == 32'd0)
    else $error("invalid byte count gave nonzero pixel");

endmodule

FILE: design/rpfc_extract.sv
// Front stages: source width mask, channel extract, scale multiply.
// Depends on rpfc_pkg.
module rpfc_extract (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rpfc_pkg::cfg_t      cfg_i,
  input  logic                valid_i,
  input  logic [31:0]         pixel_i,
  output logic                valid_o,
  output logic [2:0][31:0]    num_o
);

  logic [2:0]       vld_q, vld_d;
  logic [31:0]      pix_q, pix_d;
  logic [2:0][15:0] chan_q, chan_d;
  logic [2:0][31:0] num_q, num_d;

  always_comb begin
    vld_d = {vld_q[1:0], valid_i};
    case (cfg_i.src_bytes)
      rpfc_pkg::Bytes1: pix_d = {24'b0, pixel_i[7:0]};
      rpfc_pkg::Bytes2: pix_d = {16'b0, pixel_i[15:0]};
      default:          pix_d = pixel_i;
    endcase
    for (int ch = 0; ch < 3; ch++) begin
      logic [31:0] shifted;
      logic [15:0] smax;
      logic [31:0] prod;
      shifted = pix_q >> rpfc_pkg::field_shift(cfg_i.src_shifts, ch);
      smax = rpfc_pkg::field_max(cfg_i.src_maxes, ch);
      chan_d[ch] = shifted[15:0] & smax;
      prod = 32'(chan_q[ch]) * 32'(rpfc_pkg::field_max(cfg_i.dst_maxes, ch));
      // add half the divisor for round-to-nearest on 4-byte sources
      num_d[ch] = (cfg_i.src_bytes == rpfc_pkg::Bytes4) ? prod + {17'b0, smax[15:1]} : prod;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q  <= pix_d;
    chan_q <= chan_d;
    num_q  <= num_d;
  end

  assign valid_o = vld_q[2];
  assign num_o   = num_q;

endmodule

FILE: design/rpfc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Quotient is known to fit 16 bits. Depends on rpfc_pkg.
module rpfc_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [31:0] num_i,
  input  logic [15:0] den_i,
  output logic        valid_o,
  output logic [15:0] quo_o
);

  localparam int N = rpfc_pkg::DivStages;

  logic [N-1:0]  vld_q;
  logic [15:0]   rem_q [N];
  logic [15:0]   lo_q  [N];
  logic [15:0]   quo_q [N];
  logic [15:0]   rem_d [N];
  logic [15:0]   lo_d  [N];
  logic [15:0]   quo_d [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [15:0] rem_in, lo_in, quo_in;

    if (k == 0) begin : g_first
      assign rem_in = num_i[31:16];
      assign lo_in  = num_i[15:0];
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign lo_in  = lo_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    always_comb begin
      logic [16:0] trial;
      logic        ge;
      trial    = {rem_in, lo_in[15]};
      ge       = trial >= {1'b0, den_i};
      rem_d[k] = ge ? 16'(trial - {1'b0, den_i}) : trial[15:0];
      lo_d[k]  = {lo_in[14:0], 1'b0};
      quo_d[k] = {quo_in[14:0], ge};
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= rem_d[k];
      lo_q[k]  <= lo_d[k];
      quo_q[k] <= quo_d[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[N-2:0], valid_i};
    end
  end

  assign valid_o = vld_q[N-1];
  assign quo_o   = quo_q[N-1];

endmodule

FILE: design/rpfc_pack.sv
// Output stage: place scaled channels, merge, cut to target width.
// Depends on rpfc_pkg.
module rpfc_pack (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rpfc_pkg::cfg_t   cfg_i,
  input  logic             valid_i,
  input  logic [2:0][15:0] quo_i,
  output logic             valid_o,
  output logic [31:0]      pixel_o
);

  logic        vld_q;
  logic [31:0] pix_q, pix_d;

  always_comb begin
    logic [31:0] merged;
    merged = '0;
    for (int ch = 0; ch < 3; ch++) begin
      // drop channels with a zero source max
      if (rpfc_pkg::field_max(cfg_i.src_maxes, ch) != 16'd0) begin
        merged = merged |
                 ({16'b0, quo_i[ch]} << rpfc_pkg::field_shift(cfg_i.dst_shifts, ch));
      end
    end
    case (cfg_i.dst_bytes)
      rpfc_pkg::Bytes1: pix_d = {24'b0, merged[7:0]};
      rpfc_pkg::Bytes2: pix_d = {16'b0, merged[15:0]};
      default:          pix_d = merged;
    endcase
    if (!rpfc_pkg::bytes_ok(cfg_i.src_bytes) || !rpfc_pkg::bytes_ok(cfg_i.dst_bytes)) begin
      pix_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_q <= pix_d;
  end

  assign valid_o = vld_q;
  assign pixel_o = pix_q;

endmodule

FILE: test/tb_top.sv
// Testbench for rgb_pixel_format_convert_top: directed and random pixels over several layouts.
// Depends on rpfc_pkg and the converter RTL; predicts each target pixel and checks it in order.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Latency = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] source_pixel_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [47:0] cfg_data_i = '0;
  logic        result_valid_o;
  logic [31:0] target_pixel_o;

  rgb_pixel_format_convert_top dut (.*);

  always #6 clk_i = ~clk_i;

  // testbench's own copy of the layout registers
  logic [47:0] smaxes, dmaxes;
  logic [14:0] sshifts, dshifts;
  logic [2:0]  sbytes, dbytes;

  logic [31:0] pending_pixels[$];
  int          errors = 0;

  function automatic logic [31:0] convert_pixel(logic [31:0] pix_in);
    logic [31:0] pix, res;
    logic [15:0] sm, dm;
    logic [4:0]  ss, ds;
    logic [63:0] v;
    res = '0;
    pix = pix_in;
    if (!(sbytes inside {rpfc_pkg::Bytes1, rpfc_pkg::Bytes2, rpfc_pkg::Bytes4}) ||
        !(dbytes inside {rpfc_pkg::Bytes1, rpfc_pkg::Bytes2, rpfc_pkg::Bytes4}))
      return '0;
    if (sbytes == rpfc_pkg::Bytes1) pix &= 32'hFF;
    else if (sbytes == rpfc_pkg::Bytes2) pix &= 32'hFFFF;
    for (int ch = 0; ch < 3; ch++) begin
      sm = smaxes[16*ch +: 16];
      dm = dmaxes[16*ch +: 16];
      ss = sshifts[5*ch +: 5];
      ds = dshifts[5*ch +: 5];
      if (sm != 0) begin
        v = 64'((pix >> ss) & {16'd0, sm}) * 64'(dm);
        if (sbytes == rpfc_pkg::Bytes4) v += 64'(sm / 2);
        v /= 64'(sm);
        res |= 32'(v << ds);
      end
    end
    if (dbytes == rpfc_pkg::Bytes1) res &= 32'hFF;
    else if (dbytes == rpfc_pkg::Bytes2) res &= 32'hFFFF;
    return res;
  endfunction

  // length of an idle gap in cycles: mostly none or short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(5, 40);
  endfunction

  // send one beat; hold start high across back-to-back beats
  task automatic send_pixel(logic [31:0] pix, bit gaps);
    int n;
    start          <= 1'b1;
    source_pixel_i <= pix;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_pixels.push_back(convert_pixel(pix));
    n = (gaps && $urandom_range(0, 1)) ? idle_len() : 0;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      rpfc_pkg::RegSrcMaxes:  smaxes  = val;
      rpfc_pkg::RegDstMaxes:  dmaxes  = val;
      rpfc_pkg::RegSrcShifts: sshifts = val[14:0];
      rpfc_pkg::RegDstShifts: dshifts = val[14:0];
      rpfc_pkg::RegSrcBytes:  sbytes  = val[2:0];
      rpfc_pkg::RegDstBytes:  dbytes  = val[2:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_layout(logic [47:0] sm, logic [47:0] dm, logic [14:0] ss,
                            logic [14:0] ds, logic [2:0] sb, logic [2:0] db);
    write_reg(rpfc_pkg::RegSrcMaxes, sm);
    write_reg(rpfc_pkg::RegDstMaxes, dm);
    write_reg(rpfc_pkg::RegSrcShifts, {33'd0, ss});
    write_reg(rpfc_pkg::RegDstShifts, {33'd0, ds});
    write_reg(rpfc_pkg::RegSrcBytes, {45'd0, sb});
    write_reg(rpfc_pkg::RegDstBytes, {45'd0, db});
  endtask

  task automatic test_reset_layout();
    send_pixel(32'h0, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_pixel(32'h00AA_55CC, 1'b0);
    send_pixel(32'h8012_3456, 1'b0);
    drain();
  endtask

  task automatic test_directed_layouts();
    // 888 -> 565, rounding 4-byte source, 2-byte target
    set_layout(48'h00FF_00FF_00FF, 48'h001F_003F_001F, 15'd272, {5'd0, 5'd5, 5'd11},
               rpfc_pkg::Bytes4, rpfc_pkg::Bytes2);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_pixel(32'h0080_8080, 1'b0);
    drain();
    set_layout(48'h001F_003F_001F, 48'hFFFF_FFFF_FFFF, {5'd0, 5'd5, 5'd11}, 15'h7FFF,
               rpfc_pkg::Bytes2, rpfc_pkg::Bytes1);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_pixel(32'h0000_F81F, 1'b0);
    drain();
    // zero source max, top-bit placement overflow
    set_layout(48'hFFFF_0000_FFFF, 48'hFFFF_FFFF_FFFF, 15'd0, {5'd31, 5'd31, 5'd20},
               rpfc_pkg::Bytes1, rpfc_pkg::Bytes4);
    send_pixel(32'h0000_00FF, 1'b0);
    send_pixel(32'hFFFF_FF01, 1'b0);
    drain();
    // invalid byte counts
    set_layout(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 15'd0, 15'd0, 3'd3,
               rpfc_pkg::Bytes4);
    send_pixel(32'h1234_5678, 1'b0);
    drain();
    set_layout(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 15'd0, 15'd0, rpfc_pkg::Bytes4,
               3'd0);
    send_pixel(32'h1234_5678, 1'b0);
    drain();
    set_layout(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 15'd0, 15'd0, 3'd7, 3'd6);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    drain();
    // index beyond the register set is dropped
    write_reg(3'd6, 48'hFFFF_FFFF_FFFF);
    write_reg(3'd7, 48'h0);
  endtask

  task automatic test_random_layouts();
    logic [2:0] bsel[3];
    bsel = '{rpfc_pkg::Bytes1, rpfc_pkg::Bytes2, rpfc_pkg::Bytes4};
    for (int phase = 0; phase < 30; phase++) begin
      set_layout(48'({$urandom(), $urandom()} >> ($urandom_range(0, 3) * 12)),
                 48'({$urandom(), $urandom()} >> ($urandom_range(0, 3) * 12)),
                 15'($urandom()), 15'($urandom()),
                 ($urandom_range(0, 19) == 0) ? 3'($urandom()) : bsel[$urandom_range(0, 2)],
                 ($urandom_range(0, 19) == 0) ? 3'($urandom()) : bsel[$urandom_range(0, 2)]);
      for (int n = 0; n < 60; n++) send_pixel($urandom(), phase % 4 != 0);
      drain();
    end
  endtask

  // results cannot be held off: compare each strobed beat against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t: unexpected target_pixel %h", $time, target_pixel_o);
        errors++;
      end else if (pending_pixels[0] !== target_pixel_o) begin
        $display("%0t: target_pixel expected %h actual %h", $time, pending_pixels[0],
                 target_pixel_o);
        errors++;
        void'(pending_pixels.pop_front());
      end else begin
        void'(pending_pixels.pop_front());
      end
    end
  end

  initial begin
    smaxes = 48'h00FF_00FF_00FF;
    dmaxes = 48'h00FF_00FF_00FF;
    sshifts = 15'd272;
    dshifts = 15'd272;
    sbytes = rpfc_pkg::Bytes4;
    dbytes = rpfc_pkg::Bytes4;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_layout();
    test_directed_layouts();
    test_random_layouts();
    drain();
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #2ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule

FILE: sim.f
design/rpfc_pkg.sv
design/rpfc_extract.sv
design/rpfc_div.sv
design/rpfc_pack.sv
design/rgb_pixel_format_convert_top.sv
test/tb_top.sv
